FILE: rtl/core/assert_macros.svh
// assertion helpers for the tokenizer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

FILE: rtl/core/cbor_pkg.sv
// ----------------------------------------------------------------------
// cbor_pkg
// shared types and constants of the cbor stream tokenizer
// ----------------------------------------------------------------------
package cbor_pkg;

  localparam int MaxDepth = 16;
  localparam int LvlW = $clog2(MaxDepth);
  localparam int DepW = 5;

  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_PAY  = 2'd1;
  localparam logic [1:0] KIND_STAT = 2'd2;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNSUP = 3'd1;
  localparam logic [2:0] ST_TRUNC = 3'd2;
  localparam logic [2:0] ST_TRAIL = 3'd3;
  localparam logic [2:0] ST_DEEP  = 3'd4;

  localparam logic [2:0] MT_BSTR = 3'd2;
  localparam logic [2:0] MT_TSTR = 3'd3;
  localparam logic [2:0] MT_ARR  = 3'd4;
  localparam logic [2:0] MT_MAP  = 3'd5;
  localparam logic [2:0] MT_TAG  = 3'd6;
  localparam logic [2:0] MT_SIMP = 3'd7;

  localparam logic [4:0] AI_ONE   = 5'd24;
  localparam logic [4:0] AI_EIGHT = 5'd27;
  localparam logic [4:0] SV_FALSE = 5'd20;
  localparam logic [4:0] SV_NULL  = 5'd22;

  typedef enum logic [2:0] {
    PH_HEADER, PH_ARG, PH_PAYLOAD, PH_DONE, PH_ERROR
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE, S_BYTE, S_POP, S_FIN, S_OUT
  } seq_t;

  typedef struct packed {
    logic [1:0]  token_kind;
    logic [2:0]  major_type;
    logic [63:0] argument;
    logic [4:0]  depth;
    logic [7:0]  payload_byte;
    logic        top_done;
    logic [2:0]  status;
  } token_t;

  // push or completion-unwind request to the stack unit
  typedef struct packed {
    logic start;
    logic push;
    logic [63:0] count;
    logic is_map;
  } stk_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic top;
    logic [DepW-1:0] level;
  } stk_stat_t;

endpackage

FILE: rtl/core/cbor_if.sv
// ----------------------------------------------------------------------
// cbor_in_if / cbor_out_if / cbor_cfg_if
// valid-ready channels of the tokenizer
// ----------------------------------------------------------------------
interface cbor_in_if;
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  logic last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface cbor_out_if;
  import cbor_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] token_kind;
  logic [2:0] major_type;
  logic [63:0] argument;
  logic [4:0] depth;
  logic [7:0] payload_byte;
  logic top_done;
  logic [2:0] status;
  modport source (output valid, token_kind, major_type, argument, depth, payload_byte,
                  top_done, status, input ready);
  modport sink (input valid, token_kind, major_type, argument, depth, payload_byte,
                top_done, status, output ready);
endinterface

interface cbor_cfg_if;
  logic valid;
  logic ready;
  logic strict_trailing;
  modport source (output valid, strict_trailing, input ready);
  modport sink (input valid, strict_trailing, output ready);
endinterface

FILE: rtl/core/cbor_stack.sv
// ----------------------------------------------------------------------
// cbor_stack
// nesting stack with one shared decrement/compare unit for the unwind
// ----------------------------------------------------------------------
module cbor_stack import cbor_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      clear,
  input  stk_cmd_t  cmd,
  output stk_stat_t stat
);

  logic [63:0] items [MaxDepth];
  logic [MaxDepth-1:0] due;
  logic [MaxDepth-1:0] is_map;
  logic [DepW-1:0] level;
  logic busy;
  logic done;
  logic top;

  logic [LvlW-1:0] idx;
  logic [63:0] dec;

  assign idx = LvlW'(level - DepW'(1));
  // shared decrement unit
  assign dec = items[idx] - 64'd1;

  // one push or one pop step per cycle
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      level <= '0;
      busy <= 1'b0;
      done <= 1'b0;
      top <= 1'b0;
    end else if (cmd.start && cmd.push) begin
      items[level[LvlW-1:0]] <= cmd.count;
      due[level[LvlW-1:0]] <= 1'b0;
      is_map[level[LvlW-1:0]] <= cmd.is_map;
      level <= level + DepW'(1);
      busy <= 1'b0;
      done <= 1'b1;
      top <= 1'b0;
    end else if (cmd.start || busy) begin
      if (level == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
        top <= 1'b1;
      end else if (is_map[idx] && !due[idx]) begin
        due[idx] <= 1'b1;
        busy <= 1'b0;
        done <= 1'b1;
        top <= 1'b0;
      end else if (dec != 64'd0) begin
        due[idx] <= 1'b0;
        items[idx] <= dec;
        busy <= 1'b0;
        done <= 1'b1;
        top <= 1'b0;
      end else begin
        // level finished, keep unwinding
        due[idx] <= 1'b0;
        level <= level - DepW'(1);
        busy <= 1'b1;
        done <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign stat = '{busy: busy, done: done, top: top, level: level};

endmodule

FILE: rtl/core/cbor_stream_tokenizer.sv
// ----------------------------------------------------------------------
// cbor_stream_tokenizer
// byte-serial checker and tokenizer for one definite-length cbor item
// ----------------------------------------------------------------------
// in: one cbor byte per request, last_byte marks the end of the buffer.
// out: at most one token per input byte (header, payload byte or status).
// cfg: strict_trailing, written by the user only while the block is idle,
// which the block does not enforce. a byte passes capture, decode and
// finish when the stack is not involved; a push or a completion that
// closes no container adds the stack step S_POP before finish. a completion
// unwinds the nesting stack through one shared decrement unit, one level
// per cycle, and the byte stays in S_POP until the unwind ends. the token
// sits in an output register from the cycle after finish; the next byte
// can be taken at the same edge the token is delivered, so a stalled
// receiver holds the block. reset clears the parse state and sets
// strict_trailing to 1; after a last_byte the parse state restarts.
// ----------------------------------------------------------------------
`include "assert_macros.svh"

module cbor_stream_tokenizer import cbor_pkg::*; (
  input logic clk,
  input logic rst,
  cbor_in_if.sink in,
  cbor_out_if.source out,
  cbor_cfg_if.sink cfg
);

  seq_t seq, seq_next;
  phase_t phase, phase_next;
  logic strict;
  logic [7:0] b;
  logic last;
  logic [63:0] acc, acc_next;
  logic [3:0] left, left_next;
  logic [2:0] pmaj, pmaj_next;
  logic [63:0] pleft, pleft_next;
  token_t tok, tok_next;
  logic have, have_next;
  logic ov, ov_next;
  stk_cmd_t cmd;
  stk_stat_t st;
  logic clr;
  logic take;
  logic [2:0] mj;
  logic [4:0] ai;
  logic [63:0] acc_shift;
  logic [63:0] ahdr;
  logic hdr_done;
  logic simp_ok;
  logic is_cont;
  logic is_str;
  logic too_deep;
  logic stk_req;

  cbor_stack u_stk (.clk(clk), .rst(rst), .clear(clr), .cmd(cmd), .stat(st));

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) strict <= 1'b1;
    else if (cfg.valid) strict <= cfg.strict_trailing;
  end

  assign in.ready = (seq == S_IDLE) && (!ov || out.ready);
  assign take = in.valid && in.ready;
  assign out.valid = ov;
  assign out.token_kind = tok.token_kind;
  assign out.major_type = tok.major_type;
  assign out.argument = tok.argument;
  assign out.depth = tok.depth;
  assign out.payload_byte = tok.payload_byte;
  assign out.top_done = tok.top_done;
  assign out.status = tok.status;

  // decode of the captured byte
  assign mj = (phase == PH_ARG) ? pmaj : b[7:5];
  assign ai = b[4:0];
  assign acc_shift = {acc[55:0], b};
  assign ahdr = (phase == PH_ARG) ? acc_shift : {59'd0, ai};
  assign hdr_done = (phase == PH_HEADER && mj != MT_SIMP && ai < AI_ONE) ||
                    (phase == PH_ARG && left == 4'd1);
  assign simp_ok = (phase == PH_HEADER) && (b[7:5] == MT_SIMP) &&
                   (ai >= SV_FALSE) && (ai <= SV_NULL);
  assign is_cont = (mj == MT_ARR) || (mj == MT_MAP);
  assign is_str = (mj == MT_BSTR) || (mj == MT_TSTR);
  assign too_deep = hdr_done && is_cont && (ahdr != 64'd0) &&
                    (st.level >= DepW'(MaxDepth));

  // does this byte need the stack unit
  always_comb begin
    stk_req = 1'b0;
    if (simp_ok) stk_req = 1'b1;
    else if (hdr_done) begin
      if (is_cont) stk_req = (ahdr == 64'd0) || (st.level < DepW'(MaxDepth));
      else if (is_str) stk_req = (ahdr == 64'd0);
      else if (mj != MT_TAG) stk_req = 1'b1;
    end else if (phase == PH_PAYLOAD) stk_req = (pleft == 64'd1);
  end

  // sequencer next state
  always_comb begin
    seq_next = seq;
    case (seq)
      S_IDLE: if (take) seq_next = S_BYTE;
      S_BYTE: seq_next = stk_req ? S_POP : S_FIN;
      S_POP: if (st.done) seq_next = S_FIN;
      S_FIN: seq_next = S_IDLE;
      default: seq_next = S_IDLE;
    endcase
  end

  // stack command
  always_comb begin
    cmd = '0;
    if (seq == S_BYTE && stk_req) begin
      cmd.start = 1'b1;
      cmd.push = hdr_done && is_cont && ahdr != 64'd0;
      cmd.count = ahdr;
      cmd.is_map = (mj == MT_MAP);
    end
  end
  assign clr = (seq == S_FIN) && last;

  // parse state and token next values
  always_comb begin
    phase_next = phase;
    acc_next = acc;
    left_next = left;
    pmaj_next = pmaj;
    pleft_next = pleft;
    tok_next = tok;
    have_next = have;
    ov_next = ov;
    if (out.valid && out.ready) ov_next = 1'b0;
    case (seq)
      S_BYTE: begin
        have_next = 1'b0;
        tok_next = '0;
        tok_next.depth = st.level;
        case (phase)
          PH_HEADER: begin
            if (b[7:5] == MT_SIMP) begin
              have_next = 1'b1;
              if (simp_ok) begin
                tok_next.major_type = MT_SIMP;
                tok_next.argument = {59'd0, ai};
              end else begin
                tok_next.token_kind = KIND_STAT;
                tok_next.status = ST_UNSUP;
                tok_next.depth = '0;
                phase_next = PH_ERROR;
              end
            end else if (ai >= AI_ONE && ai <= AI_EIGHT) begin
              acc_next = '0;
              left_next = 4'd1 << ai[1:0];
              pmaj_next = mj;
              phase_next = PH_ARG;
            end else if (ai > AI_EIGHT) begin
              have_next = 1'b1;
              tok_next.token_kind = KIND_STAT;
              tok_next.status = ST_UNSUP;
              tok_next.depth = '0;
              phase_next = PH_ERROR;
            end
          end
          PH_ARG: begin
            acc_next = acc_shift;
            left_next = left - 4'd1;
          end
          PH_PAYLOAD: begin
            have_next = 1'b1;
            tok_next.token_kind = KIND_PAY;
            tok_next.major_type = pmaj;
            tok_next.payload_byte = b;
            pleft_next = pleft - 64'd1;
          end
          PH_DONE: if (strict) begin
            have_next = 1'b1;
            tok_next.token_kind = KIND_STAT;
            tok_next.status = ST_TRAIL;
            tok_next.depth = '0;
            phase_next = PH_ERROR;
          end
          default: ;
        endcase
        // complete item header
        if (hdr_done) begin
          have_next = 1'b1;
          tok_next.major_type = mj;
          tok_next.argument = ahdr;
          phase_next = PH_HEADER;
          if (is_str && ahdr != 64'd0) begin
            pmaj_next = mj;
            pleft_next = ahdr;
            phase_next = PH_PAYLOAD;
          end else if (too_deep) begin
            tok_next = '0;
            tok_next.token_kind = KIND_STAT;
            tok_next.status = ST_DEEP;
            phase_next = PH_ERROR;
          end
        end
      end
      S_POP: if (st.done) begin
        tok_next.top_done = st.top;
        phase_next = st.top ? PH_DONE : PH_HEADER;
      end
      S_FIN: begin
        if (last) begin
          if (phase != PH_DONE && phase != PH_ERROR) begin
            tok_next.status = ST_TRUNC;
            if (!have) begin
              tok_next = '0;
              tok_next.token_kind = KIND_STAT;
              tok_next.status = ST_TRUNC;
            end
            ov_next = 1'b1;
          end else begin
            ov_next = have;
          end
          phase_next = PH_HEADER;
          left_next = '0;
        end else begin
          ov_next = have;
        end
      end
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= S_IDLE;
      phase <= PH_HEADER;
      acc <= '0;
      left <= '0;
      pmaj <= '0;
      pleft <= '0;
      tok <= '0;
      have <= 1'b0;
      ov <= 1'b0;
      b <= '0;
      last <= 1'b0;
    end else begin
      seq <= seq_next;
      phase <= phase_next;
      acc <= acc_next;
      left <= left_next;
      pmaj <= pmaj_next;
      pleft <= pleft_next;
      tok <= tok_next;
      have <= have_next;
      ov <= ov_next;
      if (take) begin
        b <= in.data_byte;
        last <= in.last_byte;
      end
    end
  end

  `ASSERT_IMPL(a_no_take_busy, clk, rst, seq != S_IDLE, !in.ready,
    "input taken while busy")
  `ASSERT_IMPL(a_depth_lim, clk, rst, 1'b1, st.level <= DepW'(MaxDepth),
    "stack level over limit")
  `ASSERT_NEXT(a_stall_hold, clk, rst, out.valid && !out.ready,
    out.valid && $stable(out.argument), "token changed under stall")

endmodule
